// ===== design/lsr_pkg.sv =====
// Shared types, codes and sizes for the linear sequence resampler.
// No dependencies; every other design file imports this package.
package lsr_pkg;

  localparam int DEF_MAX_ROWS     = 256;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int ROW_IDX_W        = 12;
  localparam int DIV_W            = 35;
  localparam int DVS_W            = 9;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 9;

  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_REQUEST = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LENGTH = 2'd1;

  localparam logic [4:0] RST_CHANNEL_COUNT = 5'd16;
  localparam logic [8:0] RST_TARGET_LENGTH = 9'd99;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [23:0] sample;
    logic [7:0]         row_request;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] value;
    logic [3:0]         channel;
    logic               last;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic {
    CMD_INTERP,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [7:0]           row;
    logic [ROW_IDX_W-1:0] last_row;
    logic [7:0]           den;
    logic [4:0]           chans;
    logic [1:0]           status;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ERR,
    B_IMUL,
    B_IDIV_GO,
    B_IDIV_WAIT,
    B_READ,
    B_DIFF,
    B_MUL,
    B_NUM,
    B_CDIV_GO,
    B_CDIV_WAIT,
    B_OUT
  } back_state_t;

endpackage

// ===== design/lsr_fifo.sv =====
// Short command queue between the front and back of the resampler.
// Depends on lsr_pkg for the command type and depth.
module lsr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lsr_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output lsr_pkg::cmd_t pop_data,
  output logic          empty
);
  import lsr_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= PW'((wr_ptr + 1'b1) % QUEUE_DEPTH);
      end
      if (pop && !empty) begin
        rd_ptr <= PW'((rd_ptr + 1'b1) % QUEUE_DEPTH);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/lsr_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on lsr_pkg for the dividend and divisor widths.
module lsr_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [34:0]      dividend,
  input  logic [8:0]       divisor,
  output logic             done,
  output logic [34:0]      quotient,
  output logic [8:0]       remainder
);
  import lsr_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic             run;
  logic [CW-1:0]    cnt;
  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] rmd;
  logic [DVS_W-1:0] dsr;
  logic [DVS_W:0]   acc;
  logic [DVS_W-1:0] rmd_next;
  logic             qbit;

  assign quotient  = quo;
  assign remainder = rmd;

  always_comb begin
    acc = {rmd, quo[DIV_W-1]};
    if (acc >= {1'b0, dsr}) begin
      rmd_next = DVS_W'(acc - {1'b0, dsr});
      qbit     = 1'b1;
    end else begin
      rmd_next = DVS_W'(acc);
      qbit     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rmd <= '0;
      dsr <= divisor;
    end else if (run) begin
      quo <= {quo[DIV_W-2:0], qbit};
      rmd <= rmd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/lsr_front.sv =====
// Front of the resampler: takes items, keeps configuration and row counters,
// writes the sample store and queues requests. Depends on lsr_pkg.
module lsr_front #(
  parameter int MAX_ROWS     = lsr_pkg::DEF_MAX_ROWS,
  parameter int MAX_CHANNELS = lsr_pkg::DEF_MAX_CHANNELS,
  parameter int AW           = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  lsr_pkg::in_item_t              req,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           busy,
  input  logic                           q_full,
  output logic                           q_push,
  output lsr_pkg::cmd_t                  q_data,
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic signed [23:0]             wr_data
);
  import lsr_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CHW = AW - RW;

  logic [4:0]     channel_count;
  logic [8:0]     target_length;
  logic [RCW-1:0] row_count;
  logic [3:0]     channel_position;
  logic           overflow_seen;

  logic [4:0]     chans;
  logic [8:0]     target;
  logic           take;
  logic           store_full;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (channel_count == 5'd0) begin
      chans = 5'd1;
    end else if (channel_count > 5'(MAX_CHANNELS)) begin
      chans = 5'(MAX_CHANNELS);
    end else begin
      chans = channel_count;
    end
    if (target_length < 9'd2) begin
      target = 9'd2;
    end else if (target_length > 9'd256) begin
      target = 9'd256;
    end else begin
      target = target_length;
    end
  end

  assign req_stall  = ((req.action == ACT_REQUEST) && q_full) ||
                      ((req.action == ACT_CLEAR) && busy);
  assign take       = req_valid && !req_stall;
  assign store_full = (row_count == RCW'(MAX_ROWS));

  assign wr_en   = take && (req.action == ACT_PUSH) && !store_full;
  assign wr_addr = {row_count[RW-1:0], channel_position[CHW-1:0]};
  assign wr_data = req.sample;

  always_comb begin
    q_push          = take && (req.action == ACT_REQUEST);
    q_data.row      = req.row_request;
    q_data.last_row = ROW_IDX_W'(row_count - RCW'(1));
    q_data.den      = 8'(target - 9'd1);
    q_data.chans    = chans;
    if (row_count == '0) begin
      q_data.kind   = CMD_ERROR;
      q_data.status = ST_EMPTY;
    end else if ({1'b0, req.row_request} >= target) begin
      q_data.kind   = CMD_ERROR;
      q_data.status = ST_RANGE;
    end else begin
      q_data.kind   = CMD_INTERP;
      q_data.status = overflow_seen ? ST_OVERFLOW : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= RST_CHANNEL_COUNT;
      target_length <= RST_TARGET_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[4:0];
        CFG_TARGET_LENGTH: target_length <= cfg_data;
        default:           channel_count <= channel_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count        <= '0;
      channel_position <= '0;
      overflow_seen    <= 1'b0;
    end else if (take) begin
      case (req.action)
        ACT_PUSH: begin
          if (store_full) begin
            overflow_seen <= 1'b1;
          end else if ({1'b0, channel_position} + 5'd1 >= chans) begin
            channel_position <= '0;
            row_count        <= row_count + 1'b1;
          end else begin
            channel_position <= channel_position + 1'b1;
          end
        end
        ACT_CLEAR: begin
          row_count        <= '0;
          channel_position <= '0;
          overflow_seen    <= 1'b0;
        end
        default: begin
          overflow_seen <= overflow_seen;
        end
      endcase
    end
  end

endmodule

// ===== design/lsr_back.sv =====
// Back of the resampler: holds the sample store and works off queued requests,
// one channel at a time, through the shared divider. Depends on lsr_pkg, lsr_div.
module lsr_back #(
  parameter int MAX_ROWS     = lsr_pkg::DEF_MAX_ROWS,
  parameter int MAX_CHANNELS = lsr_pkg::DEF_MAX_CHANNELS,
  parameter int AW           = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [23:0] wr_data,
  input  logic               q_empty,
  input  lsr_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_stall,
  output lsr_pkg::out_item_t res
);
  import lsr_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CHW = AW - RW;
  localparam int PW  = 8 + RW;

  back_state_t state;
  back_state_t state_next;

  logic signed [23:0] store [2**AW];
  logic signed [23:0] rd_a;
  logic signed [23:0] rd_b;

  cmd_t               cmd;
  logic [PW-1:0]      pos;
  logic [RW-1:0]      idx;
  logic [7:0]         rem;
  logic [3:0]         ch;
  logic signed [23:0] a_val;
  logic signed [24:0] diff;
  logic signed [33:0] prod;
  logic signed [34:0] num;
  logic               neg;
  logic signed [25:0] incr;

  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [DVS_W-1:0]   div_rmd;

  logic               out_free;
  logic               out_load;
  logic               last_ch;
  logic [25:0]        q_mag;
  logic [AW-1:0]      addr_a;
  logic [AW-1:0]      addr_b;

  assign idle     = (state == B_IDLE);
  assign out_free = !res_valid || !res_stall;
  assign last_ch  = ({1'b0, ch} + 5'd1 == cmd.chans);
  assign addr_a   = {idx, ch[CHW-1:0]};
  assign addr_b   = {RW'(idx + 1'b1), ch[CHW-1:0]};
  assign q_mag    = 26'(div_quo);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_a <= store[addr_a];
    rd_b <= store[addr_b];
  end

  lsr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rmd)
  );

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = (q_head.kind == CMD_ERROR) ? B_ERR : B_IMUL;
        end
      end
      B_ERR:       if (out_free) state_next = B_IDLE;
      B_IMUL:      state_next = B_IDIV_GO;
      B_IDIV_GO:   state_next = B_IDIV_WAIT;
      B_IDIV_WAIT: if (div_done) state_next = B_READ;
      B_READ:      state_next = B_DIFF;
      B_DIFF:      state_next = (rem == 8'd0) ? B_OUT : B_MUL;
      B_MUL:       state_next = B_NUM;
      B_NUM:       state_next = B_CDIV_GO;
      B_CDIV_GO:   state_next = B_CDIV_WAIT;
      B_CDIV_WAIT: if (div_done) state_next = B_OUT;
      B_OUT: begin
        if (out_free) begin
          state_next = last_ch ? B_IDLE : B_READ;
        end
      end
      default:     state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    div_dividend = DIV_W'(pos);
    div_divisor  = {1'b0, cmd.den};
    case (state)
      B_IDLE:    q_pop = !q_empty;
      B_ERR:     out_load = out_free;
      B_IDIV_GO: div_start = 1'b1;
      B_CDIV_GO: begin
        div_start    = 1'b1;
        div_dividend = num[34] ? DIV_W'(-num) : DIV_W'(num);
        div_divisor  = {cmd.den, 1'b0};
      end
      B_OUT:     out_load = out_free;
      default:   q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          cmd <= q_head;
        end
      end
      B_IMUL: begin
        pos <= PW'(cmd.row) * PW'(cmd.last_row[RW-1:0]);
      end
      B_IDIV_WAIT: begin
        if (div_done) begin
          idx <= div_quo[RW-1:0];
          rem <= div_rmd[7:0];
          ch  <= '0;
        end
      end
      B_DIFF: begin
        a_val <= rd_a;
        diff  <= 25'(rd_b) - 25'(rd_a);
        incr  <= '0;
      end
      B_MUL: begin
        prod <= diff * $signed({1'b0, rem});
      end
      B_NUM: begin
        num <= {prod, 1'b0} + 35'(cmd.den);
      end
      B_CDIV_GO: begin
        neg <= num[34];
      end
      B_CDIV_WAIT: begin
        if (div_done) begin
          if (neg) begin
            incr <= -$signed(q_mag + 26'(div_rmd != '0));
          end else begin
            incr <= $signed(q_mag);
          end
        end
      end
      B_OUT: begin
        if (out_free && !last_ch) begin
          ch <= ch + 1'b1;
        end
      end
      default: begin
        ch <= ch;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == B_ERR) begin
        res.value   <= '0;
        res.channel <= '0;
        res.last    <= 1'b1;
        res.status  <= cmd.status;
      end else begin
        res.value   <= 24'(26'(a_val) + incr);
        res.channel <= ch;
        res.last    <= last_ch;
        res.status  <= cmd.status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule

// ===== design/linear_sequence_resampler.sv =====
// Linear sequence resampler: push items are never stalled.
// A request passes a 4-deep queue; an error answer skips the divider, while an
// interpolated row needs the row-position divide plus one divide per channel
// (none when the position falls on a stored row), all on the shared 35-step
// divider (one bit a cycle).
// A clear is held off until every queued request has been worked off.
// Reset (rst, synchronous) empties store bookkeeping, queue and output.
module linear_sequence_resampler #(
  parameter int MAX_ROWS     = lsr_pkg::DEF_MAX_ROWS,
  parameter int MAX_CHANNELS = lsr_pkg::DEF_MAX_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  lsr_pkg::in_item_t              req,
  output logic                           res_valid,
  input  logic                           res_stall,
  output lsr_pkg::out_item_t             res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsr_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW  = RW + CHW;

  logic               q_full;
  logic               q_empty;
  logic               q_push;
  logic               q_pop;
  cmd_t               q_data;
  cmd_t               q_head;
  logic               back_idle;
  logic               busy;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [23:0] wr_data;

  assign busy = !q_empty || !back_idle;

  lsr_front #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  lsr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  lsr_back #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .AW           (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .idle      (back_idle),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== design/lsr_checker.sv =====
// Port-level checks for the resampler result channel, bound to the top level.
// Depends on lsr_pkg and linear_sequence_resampler.
module lsr_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_stall,
  input lsr_pkg::out_item_t res
);
  import lsr_pkg::*;

  logic [3:0] exp_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_ch <= '0;
    end else if (res_valid && !res_stall) begin
      exp_ch <= res.last ? 4'd0 : res.channel + 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_EMPTY || res.status == ST_RANGE) |->
      res.last && res.value == '0 && res.channel == '0)
    else $error("error result not a single zero item");

  a_ch_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_OK || res.status == ST_OVERFLOW) |->
      res.channel == exp_ch)
    else $error("channel out of sequence");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind linear_sequence_resampler lsr_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

// ===== tb/linear_sequence_resampler_tb.sv =====
`timescale 1ns / 100ps

// Testbench for linear_sequence_resampler: pushes multi-channel rows, requests
// resampled rows and checks each channel result against an in-bench predictor.
// Depends on lsr_pkg and the design sources only.
module linear_sequence_resampler_tb;
  import lsr_pkg::*;

  localparam int unsigned ROW_LIMIT   = DEF_MAX_ROWS;
  localparam int unsigned CHAN_LIMIT  = DEF_MAX_CHANNELS;
  localparam int unsigned SPAN_LIMIT  = 256;
  localparam int unsigned ITEM_GOAL   = 410;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned TAIL        = 64;

  localparam logic [1:0]           ACT_IDLE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam logic [23:0]          SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [23:0]          SAMPLE_MIN = 24'h800000;

  class resample_scoreboard;
    logic signed [23:0] store [ROW_LIMIT*CHAN_LIMIT];
    int unsigned        rows;
    int unsigned        chan_pos;
    bit                 overflow;
    logic [4:0]         chan_reg;
    logic [8:0]         len_reg;
    out_item_t          resampled_values[$];
    int unsigned        errors;

    function new();
      rows     = 0;
      chan_pos = 0;
      overflow = 1'b0;
      chan_reg = RST_CHANNEL_COUNT;
      len_reg  = RST_TARGET_LENGTH;
      errors   = 0;
    endfunction

    function int unsigned chans();
      if (chan_reg == 0) return 1;
      if (chan_reg > CHAN_LIMIT) return CHAN_LIMIT;
      return chan_reg;
    endfunction

    function int unsigned span();
      if (len_reg < 2) return 2;
      if (len_reg > SPAN_LIMIT) return SPAN_LIMIT;
      return len_reg;
    endfunction

    function int unsigned pending();
      return resampled_values.size();
    endfunction

    function void add_expected(out_item_t r);
      resampled_values = {resampled_values, r};
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_CHANNEL_COUNT) chan_reg = data[4:0];
      else if (idx == CFG_TARGET_LENGTH) len_reg = data[8:0];
    endfunction

    function void interpolate_row(int unsigned j);
      longint    den, p, base, frac, a, b, num, v;
      out_item_t r;
      logic [1:0] st;
      r = '0;
      r.last = 1'b1;
      if (rows == 0) begin
        r.status = ST_EMPTY;
        add_expected(r);
        return;
      end
      if (j >= span()) begin
        r.status = ST_RANGE;
        add_expected(r);
        return;
      end
      st = overflow ? ST_OVERFLOW : ST_OK;
      den = span() - 1;
      p = longint'(j) * longint'(rows - 1);
      base = p / den;
      frac = p % den;
      for (int c = 0; c < chans(); c++) begin
        a = store[base * CHAN_LIMIT + c];
        v = a;
        if (frac != 0) begin
          b = store[(base + 1) * CHAN_LIMIT + c];
          num = 2 * (b - a) * frac + den;
          v = a + ((num >= 0) ? num / (2 * den) : -((2 * den - 1 - num) / (2 * den)));
        end
        r.value   = v[23:0];
        r.channel = c[3:0];
        r.last    = (c + 1 == chans());
        r.status  = st;
        add_expected(r);
      end
    endfunction

    function void note_item(in_item_t it);
      case (it.action)
        ACT_PUSH: begin
          if (rows >= ROW_LIMIT) begin
            overflow = 1'b1;
          end else begin
            if (chan_pos >= CHAN_LIMIT) chan_pos = 0;
            store[rows * CHAN_LIMIT + chan_pos] = it.sample;
            if (chan_pos + 1 >= chans()) begin
              chan_pos = 0;
              rows++;
            end else begin
              chan_pos++;
            end
          end
        end
        ACT_REQUEST: interpolate_row(it.row_request);
        ACT_CLEAR: begin
          rows     = 0;
          chan_pos = 0;
          overflow = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void flag(string field, logic signed [31:0] want, logic signed [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (resampled_values.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual value %0d channel %0d status %0d",
                 $time, got.value, got.channel, got.status);
        return;
      end
      want = resampled_values.pop_front();
      if (got.value !== want.value) flag("value", want.value, got.value);
      if (got.channel !== want.channel) flag("channel", want.channel, got.channel);
      if (got.last !== want.last) flag("last", want.last, got.last);
      if (got.status !== want.status) flag("status", want.status, got.status);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_stall;
  in_item_t              req;
  logic                  res_valid;
  logic                  res_stall;
  out_item_t             res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  resample_scoreboard sb;
  bit                 sender_quiet;
  bit                 receiver_quiet;
  int unsigned        items_sent = 0;
  int unsigned        cycles = 0;

  linear_sequence_resampler i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("linear_sequence_resampler_tb: FAIL");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [23:0] draw_sample();
    case ($urandom_range(0, 5))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return 24'($urandom_range(0, 1023) - 512);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send(logic [1:0] act, logic [23:0] smp, logic [7:0] row);
    in_item_t    it;
    int unsigned gap;
    it.action      = act;
    it.sample      = smp;
    it.row_request = row;
    gap = draw_wait(sender_quiet);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    do @(posedge clk); while (req_stall);
    sb.note_item(it);
    if (act != ACT_IDLE) items_sent++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_register(idx, data);
  endtask

  task automatic push_row();
    repeat (sb.chans()) send(ACT_PUSH, draw_sample(), 8'($urandom));
  endtask

  // Fill every row with one channel, then push past the end.
  task automatic fill_store();
    write_reg(CFG_CHANNEL_COUNT, 9'd0);
    write_reg(CFG_TARGET_LENGTH, 9'($urandom_range(2, SPAN_LIMIT)));
    send(ACT_CLEAR, 24'($urandom), 8'($urandom));
    for (int k = 0; k < ROW_LIMIT + 4; k++) begin
      send(ACT_PUSH, draw_sample(), 8'($urandom));
      if (k % 37 == 0) begin
        send(ACT_REQUEST, 24'($urandom), 8'($urandom_range(0, sb.span() - 1)));
      end
    end
    repeat (4) send(ACT_REQUEST, 24'($urandom), 8'($urandom_range(0, sb.span() - 1)));
    send(ACT_CLEAR, 24'($urandom), 8'($urandom));
    send(ACT_PUSH, draw_sample(), 8'($urandom));
    send(ACT_REQUEST, 24'($urandom), 8'd0);
  endtask

  task automatic run_phase();
    int unsigned steps, pick, j;
    sender_quiet   = ($urandom_range(0, 3) == 0);
    receiver_quiet = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 7))
      0: write_reg(CFG_TARGET_LENGTH, 9'($urandom_range(0, 1)));
      1: write_reg(CFG_TARGET_LENGTH, 9'(SPAN_LIMIT));
      2: write_reg(CFG_TARGET_LENGTH, 9'($urandom_range(SPAN_LIMIT + 1, 511)));
      3: write_reg(CFG_TARGET_LENGTH, 9'd2);
      default: write_reg(CFG_TARGET_LENGTH, 9'($urandom_range(3, 40)));
    endcase
    // Change the channel count only together with a clear.
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 5))
        0: pick = 0;
        1: pick = $urandom_range(CHAN_LIMIT + 1, 31);
        2: pick = CHAN_LIMIT;
        default: pick = $urandom_range(1, 4);
      endcase
      write_reg(CFG_CHANNEL_COUNT, 9'(($urandom_range(0, 15) << 5) | pick));
      send(ACT_CLEAR, 24'($urandom), 8'($urandom));
    end
    repeat ($urandom_range(1, 6)) push_row();
    steps = $urandom_range(12, 40);
    for (int k = 0; k < steps && items_sent < ITEM_GOAL; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        push_row();
      end else if (pick < 70) begin
        j = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                        : $urandom_range(0, sb.span() - 1);
        send(ACT_REQUEST, 24'($urandom), 8'(j));
        if ($urandom_range(0, 14) == 0) drain();
      end else if (pick < 82) begin
        send(ACT_PUSH, draw_sample(), 8'($urandom));
      end else if (pick < 87) begin
        send(ACT_CLEAR, 24'($urandom), 8'($urandom));
      end else if (pick < 92) begin
        send(ACT_IDLE, 24'($urandom), 8'($urandom));
      end else begin
        send(ACT_REQUEST, 24'($urandom), 8'($urandom_range(sb.span() - 1, 255)));
      end
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    res_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = draw_wait(receiver_quiet);
      if (hold != 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
      sb.check_result(res);
    end
  end

  initial begin : stimulus
    sb = new();
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send(ACT_REQUEST, 24'($urandom), 8'd0);
    send(ACT_REQUEST, 24'($urandom), 8'd255);
    write_reg(CFG_SPARE, 9'($urandom));
    write_reg(CFG_CHANNEL_COUNT, {4'hA, 5'd2});
    send(ACT_PUSH, SAMPLE_MAX, 8'($urandom));
    send(ACT_PUSH, SAMPLE_MIN, 8'($urandom));
    send(ACT_REQUEST, 24'($urandom), 8'd99);
    send(ACT_REQUEST, 24'($urandom), 8'd98);
    write_reg(CFG_TARGET_LENGTH, 9'd5);
    send(ACT_REQUEST, 24'($urandom), 8'd4);
    send(ACT_REQUEST, 24'($urandom), 8'd5);
    send(ACT_PUSH, SAMPLE_MIN, 8'($urandom));
    send(ACT_PUSH, SAMPLE_MAX, 8'($urandom));
    send(ACT_REQUEST, 24'($urandom), 8'd2);
    send(ACT_REQUEST, 24'($urandom), 8'd1);
    send(ACT_PUSH, 24'd3, 8'($urandom));
    send(ACT_PUSH, 24'h800002, 8'($urandom));
    send(ACT_REQUEST, 24'($urandom), 8'd3);
    send(ACT_REQUEST, 24'($urandom), 8'd4);
    send(ACT_IDLE, 24'($urandom), 8'($urandom));
    send(ACT_PUSH, 24'd5, 8'($urandom));
    send(ACT_REQUEST, 24'($urandom), 8'd4);
    write_reg(CFG_CHANNEL_COUNT, 9'd1);
    send(ACT_PUSH, 24'd7, 8'($urandom));
    send(ACT_REQUEST, 24'($urandom), 8'd4);
    send(ACT_CLEAR, 24'($urandom), 8'($urandom));
    send(ACT_REQUEST, 24'($urandom), 8'd0);

    fill_store();
    while (items_sent < ITEM_GOAL) run_phase();

    drain();
    repeat (TAIL) @(posedge clk);
    if (sb.errors == 0) $display("linear_sequence_resampler_tb: PASS");
    else $display("linear_sequence_resampler_tb: FAIL");
    $finish;
  end

endmodule
